[hdl/knnlas_pkg.sv]
// ----------------------------------------------------------------------------
// knnlas_pkg
// Shared constants and types of the k-nearest-neighbour agreement statistics.
// ----------------------------------------------------------------------------
package knnlas_pkg;

  // Default sizing of the kept list and of the distance datapath.
  localparam int MAX_K_DEF     = 16;
  localparam int DIST_BITS_DEF = 32;

  // Value of k after reset.
  localparam logic [4:0] K_RESET = 5'd3;

  // Width of the quotient bit counter of the divider (covers up to 63 bits).
  localparam int QCNT_W = 6;

  // Full-scale value of the 16-bit fractions.
  localparam logic [15:0] FULL_SCALE = 16'hFFFF;

  // Number of quotient bits of a scaled fraction.
  localparam int FRAC_QBITS = 16;

  // Control from the sequencer to the divider.
  typedef struct packed {
    logic              start;
    logic [QCNT_W-1:0] qbits;
  } div_ctl_t;

  // Status from the divider to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

[hdl/knnlas_ram.sv]
// ----------------------------------------------------------------------------
// knnlas_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module knnlas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/knnlas_div.sv]
// ----------------------------------------------------------------------------
// knnlas_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module knnlas_div
  import knnlas_pkg::*;
#(
  parameter int WW = 64,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  div_ctl_t      ctl,
  input  logic [WW-1:0] num,
  input  logic [WW-1:0] dsh,
  output logic [QW-1:0] quot,
  output div_sts_t      sts
);

  logic [WW-1:0]     rem_r, rem_nxt;
  logic [WW-1:0]     dsh_r, dsh_nxt;
  logic [QW-1:0]     q_r, q_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              ge;

  // One trial subtraction of the shifted divisor per cycle.
  always_comb begin
    ge       = (dsh_r <= rem_r);
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      rem_nxt  = num;
      dsh_nxt  = dsh;
      q_nxt    = '0;
      cnt_nxt  = ctl.qbits;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r;
      end
      q_nxt   = {q_r[QW-2:0], ge};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == QCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control flags are reset; the datapath is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  assign quot     = q_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

[hdl/knn_label_agreement_stats.sv]
// ----------------------------------------------------------------------------
// knn_label_agreement_stats
// Keeps the k nearest neighbours of a query and reports label agreement.
// ----------------------------------------------------------------------------
// Neighbour requests are taken one at a time; in_tready is high only while the
// block is idle. A neighbour is inserted by walking the kept list from its end
// through a RAM with a registered read, each entry visited in a read and a
// compare state, until an entry with a smaller or equal distance or the head
// of the list is reached. The request flagged by in_tlast then adds up the n
// kept entries, forms the two serial products, and makes four passes of a
// shared bit-serial divider (a pass that is not needed, such as the average of
// an empty group, is skipped without starting the divider), and then loads the
// result, which is offered on out_*. The next query can start while that
// result waits to be taken. No clearing pass is needed: the fill count tells
// which entries are valid.
// ----------------------------------------------------------------------------
module knn_label_agreement_stats
  import knnlas_pkg::*;
#(
  parameter int MAX_K     = MAX_K_DEF,
  parameter int DIST_BITS = DIST_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // Configuration: k.
  input  logic         cfg_we,
  input  logic [4:0]   cfg_wdata,
  // Neighbour requests.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] neighbor_distance
  input  logic         in_tuser,   // [0] same_label
  input  logic         in_tlast,   // last_neighbor
  // Result requests.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata   // [4:0] same_count, [9:5] diff_count,
                                   // [41:10] same_avg_distance,
                                   // [73:42] diff_avg_distance,
                                   // [89:74] same_share, [105:90] distance_ratio
);

  localparam int CW = $clog2(MAX_K + 1);
  localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int SW = DIST_BITS + CW;
  localparam int PW = SW + CW;
  localparam int WW = PW + 17;
  localparam int QW = (DIST_BITS > 16) ? DIST_BITS : 16;
  localparam int MW = $clog2(CW + 1);
  localparam int EW = DIST_BITS + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_ST_RD, S_ST_ACC, S_MUL, S_DIV_GO, S_DIV_WAIT, S_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  logic [4:0]      k_r, k_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [CW-1:0]   keff_r, keff_nxt;
  logic [CW-1:0]   n_r, n_nxt;
  logic [CW-1:0]   jp_r, jp_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [DIST_BITS-1:0] d_r, d_nxt;
  logic            s_r, s_nxt;
  logic            last_r, last_nxt;
  logic [CW-1:0]   cs_r, cs_nxt, cd_r, cd_nxt;
  logic [SW-1:0]   ss_r, ss_nxt, sd_r, sd_nxt;
  logic [PW-1:0]   p1_r, p1_nxt, p2_r, p2_nxt;
  logic [CW-1:0]   ms_r, ms_nxt, md_r, md_nxt;
  logic [MW-1:0]   mc_r, mc_nxt;
  logic [1:0]      sel_r, sel_nxt;
  logic [QW-1:0]   avs_r, avs_nxt, avd_r, avd_nxt;
  logic [15:0]     shr_r, shr_nxt, rat_r, rat_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [111:0]    out_data_r, out_data_nxt;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [EW-1:0]   wdata, rdata;
  logic [DIST_BITS+31:0] din_ext;
  logic [CW+4:0]   k_ext;
  logic [CW-1:0]   keff_in, n_in, n_ins;
  logic [CW+4:0]   cs_ext, cd_ext;
  logic [QW+31:0]  avs_ext, avd_ext;
  logic [WW-1:0]   dv_num, dv_dsh;
  logic [QW-1:0]   dv_quot;
  logic            dv_skip;
  logic [15:0]     dv_skip_val;
  div_ctl_t        dv_ctl;
  div_sts_t        dv_sts;
  logic            emit;

  // Kept list: distance with the label flag on top.
  knnlas_ram #(.WIDTH(EW), .DEPTH(MAX_K)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Shared divider for the averages and both fractions.
  knnlas_div #(.WW(WW), .QW(QW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (dv_ctl),
    .num   (dv_num),
    .dsh   (dv_dsh),
    .quot  (dv_quot),
    .sts   (dv_sts)
  );

  // Input distance at the datapath width, and k clamped to 1..MAX_K.
  assign din_ext = {{DIST_BITS{1'b0}}, in_tdata};
  assign k_ext   = {{CW{1'b0}}, k_r};
  always_comb begin
    if (k_r == 5'd0) begin
      keff_in = CW'(1);
    end else if (k_ext > (CW + 5)'(MAX_K)) begin
      keff_in = CW'(MAX_K);
    end else begin
      keff_in = k_ext[CW-1:0];
    end
    n_in  = (fill_r < keff_in) ? fill_r : keff_in;
    n_ins = (n_r < keff_r) ? n_r + 1'b1 : n_r;
  end

  // Divider operands for each of the four passes.
  always_comb begin
    dv_num      = '0;
    dv_dsh      = '0;
    dv_ctl.qbits = QCNT_W'(FRAC_QBITS);
    dv_skip     = 1'b0;
    dv_skip_val = '0;
    case (sel_r)
      2'd0: begin
        dv_num       = WW'(ss_r);
        dv_dsh       = WW'(cs_r) << (DIST_BITS - 1);
        dv_ctl.qbits = QCNT_W'(DIST_BITS);
        dv_skip      = (cs_r == '0);
      end
      2'd1: begin
        dv_num       = WW'(sd_r);
        dv_dsh       = WW'(cd_r) << (DIST_BITS - 1);
        dv_ctl.qbits = QCNT_W'(DIST_BITS);
        dv_skip      = (cd_r == '0);
      end
      2'd2: begin
        dv_num = (WW'(cs_r) << 16) - WW'(cs_r);
        dv_dsh = (WW'(cs_r) + WW'(cd_r)) << (FRAC_QBITS - 1);
      end
      default: begin
        dv_num = (WW'(p1_r) << 16) - WW'(p1_r);
        dv_dsh = (WW'(p1_r) + WW'(p2_r)) << (FRAC_QBITS - 1);
        if (sd_r == '0) begin
          dv_skip     = 1'b1;
          dv_skip_val = FULL_SCALE;
        end else if (ss_r == '0) begin
          dv_skip = 1'b1;
        end
      end
    endcase
    dv_ctl.start = (state_r == S_DIV_GO) && !dv_skip;
  end

  // Result fields at their port widths.
  assign cs_ext  = {5'b0, cs_r};
  assign cd_ext  = {5'b0, cd_r};
  assign avs_ext = {32'b0, avs_r};
  assign avd_ext = {32'b0, avd_r};
  assign emit    = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = cfg_we ? cfg_wdata : k_r;
    fill_nxt      = fill_r;
    keff_nxt      = keff_r;
    n_nxt         = n_r;
    jp_nxt        = jp_r;
    i_nxt         = i_r;
    d_nxt         = d_r;
    s_nxt         = s_r;
    last_nxt      = last_r;
    cs_nxt        = cs_r;
    cd_nxt        = cd_r;
    ss_nxt        = ss_r;
    sd_nxt        = sd_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    ms_nxt        = ms_r;
    md_nxt        = md_r;
    mc_nxt        = mc_r;
    sel_nxt       = sel_r;
    avs_nxt       = avs_r;
    avd_nxt       = avd_r;
    shr_nxt       = shr_r;
    rat_nxt       = rat_r;
    out_valid_nxt = (out_valid_r && out_tready) ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    waddr         = AW'(jp_r);
    wdata         = {s_r, d_r};
    raddr         = '0;
    in_tready     = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          d_nxt     = din_ext[DIST_BITS-1:0];
          s_nxt     = in_tuser;
          last_nxt  = in_tlast;
          keff_nxt  = keff_in;
          n_nxt     = n_in;
          jp_nxt    = n_in;
          state_nxt = S_INS_RD;
        end
      end
      // Visit the entry just above the insertion point.
      S_INS_RD: begin
        raddr = AW'(jp_r - 1'b1);
        if (jp_r == '0) begin
          we       = 1'b1;
          fill_nxt = n_ins;
          n_nxt    = n_ins;
          i_nxt    = '0;
          cs_nxt   = '0;
          cd_nxt   = '0;
          ss_nxt   = '0;
          sd_nxt   = '0;
          state_nxt = last_r ? S_ST_RD : S_IDLE;
        end else begin
          state_nxt = S_INS_CMP;
        end
      end
      // Larger entries move down one place; the new one lands after the rest.
      S_INS_CMP: begin
        if (rdata[DIST_BITS-1:0] > d_r) begin
          we        = (jp_r < keff_r);
          wdata     = rdata;
          jp_nxt    = jp_r - 1'b1;
          state_nxt = S_INS_RD;
        end else begin
          we        = (jp_r < keff_r);
          fill_nxt  = n_ins;
          n_nxt     = n_ins;
          i_nxt     = '0;
          cs_nxt    = '0;
          cd_nxt    = '0;
          ss_nxt    = '0;
          sd_nxt    = '0;
          state_nxt = last_r ? S_ST_RD : S_IDLE;
        end
      end
      S_ST_RD: begin
        raddr     = AW'(i_r);
        state_nxt = S_ST_ACC;
      end
      // Count and sum the kept entries by label.
      S_ST_ACC: begin
        if (rdata[DIST_BITS]) begin
          cs_nxt = cs_r + 1'b1;
          ss_nxt = ss_r + SW'(rdata[DIST_BITS-1:0]);
        end else begin
          cd_nxt = cd_r + 1'b1;
          sd_nxt = sd_r + SW'(rdata[DIST_BITS-1:0]);
        end
        i_nxt = i_r + 1'b1;
        if (i_r + 1'b1 == n_r) begin
          p1_nxt    = '0;
          p2_nxt    = '0;
          ms_nxt    = cs_nxt;
          md_nxt    = cd_nxt;
          mc_nxt    = MW'(CW);
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_ST_RD;
        end
      end
      // Shift-and-add products SumDiff*CountSame and SumSame*CountDiff.
      S_MUL: begin
        p1_nxt = (p1_r << 1) + (ms_r[CW-1] ? PW'(sd_r) : '0);
        p2_nxt = (p2_r << 1) + (md_r[CW-1] ? PW'(ss_r) : '0);
        ms_nxt = ms_r << 1;
        md_nxt = md_r << 1;
        mc_nxt = mc_r - 1'b1;
        if (mc_r == MW'(1)) begin
          sel_nxt   = '0;
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        if (dv_skip) begin
          case (sel_r)
            2'd0:    avs_nxt = '0;
            2'd1:    avd_nxt = '0;
            2'd2:    shr_nxt = '0;
            default: rat_nxt = dv_skip_val;
          endcase
          sel_nxt   = sel_r + 1'b1;
          state_nxt = (sel_r == 2'd3) ? S_EMIT : S_DIV_GO;
        end else begin
          state_nxt = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (dv_sts.done) begin
          case (sel_r)
            2'd0:    avs_nxt = dv_quot;
            2'd1:    avd_nxt = dv_quot;
            2'd2:    shr_nxt = dv_quot[15:0];
            default: rat_nxt = dv_quot[15:0];
          endcase
          sel_nxt   = sel_r + 1'b1;
          state_nxt = (sel_r == 2'd3) ? S_EMIT : S_DIV_GO;
        end
      end
      // Hand the result over once the output register is free.
      S_EMIT: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'b0, rat_r, shr_r, avd_ext[31:0], avs_ext[31:0],
                           cd_ext[4:0], cs_ext[4:0]};
          fill_nxt      = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= K_RESET;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    keff_r     <= keff_nxt;
    n_r        <= n_nxt;
    jp_r       <= jp_nxt;
    i_r        <= i_nxt;
    d_r        <= d_nxt;
    s_r        <= s_nxt;
    last_r     <= last_nxt;
    cs_r       <= cs_nxt;
    cd_r       <= cd_nxt;
    ss_r       <= ss_nxt;
    sd_r       <= sd_nxt;
    p1_r       <= p1_nxt;
    p2_r       <= p2_nxt;
    ms_r       <= ms_nxt;
    md_r       <= md_nxt;
    mc_r       <= mc_nxt;
    sel_r      <= sel_nxt;
    avs_r      <= avs_nxt;
    avd_r      <= avd_nxt;
    shr_r      <= shr_nxt;
    rat_r      <= rat_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  // The fill count never passes the list depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(MAX_K))
    else $error("kept fill count beyond MAX_K");

  // The divider is only started when it is free.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    dv_ctl.start |-> !dv_sts.busy)
    else $error("divider started while busy");

  // Emitting a result clears the kept list for the next query.
  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (fill_r == '0) && out_tvalid)
    else $error("result emitted without clearing the kept list");
`endif

endmodule

[test/knn_label_agreement_stats_test.sv]
// ----------------------------------------------------------------------------
// knn_label_agreement_stats_test
// Self-checking bench for the k-nearest-neighbour agreement statistics block.
// ----------------------------------------------------------------------------
// Neighbour requests are queued by an initial block and driven by a clocked
// driver. Each accepted request is run through a behavioural model of the kept
// list, and results are compared field by field with the oldest expectation.
// The run goes through several values of k, random idling on both sides, and
// one long receiver hold-off that makes the block stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module knn_label_agreement_stats_test;
  import knnlas_pkg::*;

  localparam int KMAX = 16;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [31:0] distance;
    logic        same;
    logic        last;
  } neighbour_t;

  typedef struct packed {
    logic [15:0] ratio;
    logic [15:0] share;
    logic [31:0] diff_avg;
    logic [31:0] same_avg;
    logic [4:0]  diff_cnt;
    logic [4:0]  same_cnt;
  } stats_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [4:0]   cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;

  // Bench state.
  neighbour_t pending_q[$];
  stats_t     expected_stats_q[$];
  logic [31:0] list_dist[KMAX];
  logic        list_same[KMAX];
  int          list_fill;
  logic [4:0]  k_setting;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_request = 1'b0;
  int          hold_count = 0;
  int          errors = 0;
  longint      cycle_count = 0;

  knn_label_agreement_stats DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  // floor(65535 * a / (a + b)), exact.
  function automatic logic [15:0] scaled_share(logic [127:0] a, logic [127:0] b);
    logic [127:0] q;
    if (a + b == 0) return '0;
    q = (a * 128'd65535) / (a + b);
    return q[15:0];
  endfunction

  // Insert one neighbour into the model list; return 1 with stats when last.
  function automatic bit insert_neighbour(neighbour_t nb, output stats_t st);
    int keff, n, pos, last_idx;
    logic [63:0] cs, cd, ss, sd;
    keff = (k_setting < 1) ? 1 : ((k_setting > KMAX) ? KMAX : int'(k_setting));
    n = (list_fill < keff) ? list_fill : keff;
    pos = 0;
    st = '0;
    while (pos < n && list_dist[pos] <= nb.distance) pos++;
    if (pos < keff) begin
      last_idx = (n < keff) ? n : keff - 1;
      for (int i = last_idx; i > pos; i--) begin
        list_dist[i] = list_dist[i-1];
        list_same[i] = list_same[i-1];
      end
      list_dist[pos] = nb.distance;
      list_same[pos] = nb.same;
      if (n < keff) n++;
    end
    list_fill = n;
    if (!nb.last) return 0;
    cs = 0; cd = 0; ss = 0; sd = 0;
    for (int i = 0; i < n; i++) begin
      if (list_same[i]) begin
        cs++; ss += list_dist[i];
      end else begin
        cd++; sd += list_dist[i];
      end
    end
    st.same_cnt = cs[4:0];
    st.diff_cnt = cd[4:0];
    st.same_avg = (cs != 0) ? 32'(ss / cs) : '0;
    st.diff_avg = (cd != 0) ? 32'(sd / cd) : '0;
    st.share = scaled_share(128'(cs), 128'(cd));
    if (sd == 0) st.ratio = FULL_SCALE;
    else if (ss == 0) st.ratio = '0;
    else st.ratio = scaled_share(128'(sd) * 128'(cs), 128'(ss) * 128'(cd));
    list_fill = 0;
    return 1;
  endfunction

  // Driver: offers queued neighbours, idling at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_q[0].distance;
          in_tuser  <= pending_q[0].same;
          in_tlast  <= pending_q[0].last;
          void'(pending_q.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Model update on each accepted neighbour request.
  always @(posedge clk) begin
    neighbour_t nb;
    stats_t st;
    if (rst_n && in_tvalid && in_tready) begin
      nb.distance = in_tdata;
      nb.same = in_tuser;
      nb.last = in_tlast;
      if (insert_neighbour(nb, st)) expected_stats_q.push_back(st);
    end
  end

  // Receiver readiness, with the long hold-off counted here.
  always @(posedge clk) begin
    if (hold_request && hold_count == 0) hold_count <= 3000;
    if (hold_count > 0) begin
      hold_count <= hold_count - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each result request with the oldest expectation.
  always @(posedge clk) begin
    stats_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[105:0];
      if (expected_stats_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_stats_q.pop_front();
        if (got.same_cnt !== want.same_cnt)
          $display("%0t: same_count exp %0d got %0d", $time, want.same_cnt, got.same_cnt);
        if (got.diff_cnt !== want.diff_cnt)
          $display("%0t: diff_count exp %0d got %0d", $time, want.diff_cnt, got.diff_cnt);
        if (got.same_avg !== want.same_avg)
          $display("%0t: same_avg exp %0d got %0d", $time, want.same_avg, got.same_avg);
        if (got.diff_avg !== want.diff_avg)
          $display("%0t: diff_avg exp %0d got %0d", $time, want.diff_avg, got.diff_avg);
        if (got.share !== want.share)
          $display("%0t: same_share exp %0d got %0d", $time, want.share, got.share);
        if (got.ratio !== want.ratio)
          $display("%0t: distance_ratio exp %0d got %0d", $time, want.ratio, got.ratio);
        if (got !== want) errors++;
      end
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("knn_label_agreement_stats regression: fail");
      $finish;
    end
  end

  task automatic queue_neighbour(logic [31:0] d, logic s, logic l);
    neighbour_t nb;
    nb.distance = d; nb.same = s; nb.last = l;
    pending_q.push_back(nb);
  endtask

  // Random distance: often small or repeated to provoke ties, sometimes extreme.
  function automatic logic [31:0] pick_distance();
    case ($urandom_range(4))
      0: return $urandom_range(7);
      1: return 32'hFFFF_FFFF - $urandom_range(3);
      2: return $urandom_range(1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_queries(int count);
    int len;
    for (int q = 0; q < count; q++) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++)
        queue_neighbour(pick_distance(), $urandom_range(1), i == len - 1);
    end
  endtask

  task automatic drain_block();
    while (pending_q.size() != 0 || in_tvalid || expected_stats_q.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_k(logic [4:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    k_setting = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    k_setting = K_RESET;
    list_fill = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 26;
    recv_idle_pct = 75;

    // Directed: reset k, single neighbour, ties, extremes, all-same, all-diff.
    queue_neighbour(32'd5, 1'b1, 1'b1);
    queue_neighbour(32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_neighbour(32'd0, 1'b1, 1'b0);
    queue_neighbour(32'd7, 1'b0, 1'b0);
    queue_neighbour(32'd7, 1'b1, 1'b0);
    queue_neighbour(32'hFFFF_FFFF, 1'b1, 1'b1);
    queue_neighbour(32'd0, 1'b0, 1'b0);
    queue_neighbour(32'd0, 1'b0, 1'b1);
    queue_neighbour(32'd9, 1'b1, 1'b0);
    queue_neighbour(32'd3, 1'b1, 1'b1);
    drain_block();

    // k = 0 acts as one; k above the maximum clamps.
    write_k(5'd0);
    queue_neighbour(32'd4, 1'b0, 1'b0);
    queue_neighbour(32'd2, 1'b1, 1'b1);
    drain_block();
    write_k(5'd31);
    for (int i = 0; i < 20; i++) queue_neighbour(32'd100 - i, i[0], i == 19);
    drain_block();

    // Change k in the middle of a query.
    write_k(5'd8);
    for (int i = 0; i < 6; i++) queue_neighbour(32'd50 + i, i[0], 1'b0);
    drain_block();
    write_k(5'd2);
    queue_neighbour(32'd1, 1'b0, 1'b1);
    drain_block();

    // Random phases over several k values.
    write_k(5'd16);
    queue_queries(18);
    drain_block();
    send_idle_pct = 75;
    recv_idle_pct = 26;
    write_k(5'd1);
    queue_queries(14);
    drain_block();
    write_k(5'($urandom_range(2, 15)));
    queue_queries(14);
    // Long receiver hold-off while the sender keeps offering.
    hold_request = 1'b1;
    wait (hold_count > 0);
    hold_request = 1'b0;
    drain_block();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_k(5'd16);
    queue_queries(14);
    drain_block();
    write_k(5'd3);
    queue_queries(11);
    drain_block();

    if (errors == 0) begin
      $display("knn_label_agreement_stats regression: pass");
    end else begin
      $display("knn_label_agreement_stats regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/knnlas_pkg.sv
hdl/knnlas_ram.sv
hdl/knnlas_div.sv
hdl/knn_label_agreement_stats.sv
test/knn_label_agreement_stats_test.sv
